### design/i4fed_pkg.sv
// Shared types, codes and constants for the int4 fractal embedding dequantizer.
package i4fed_pkg;

   localparam int BLOB_BYTES = 65536;
   localparam int ADDR_W = $clog2(BLOB_BYTES);
   // Largest group count whose weights and scales fit the store (18 bytes a group).
   localparam int MAX_GROUPS = BLOB_BYTES / 18;

   localparam logic [12:0] ROW_COUNT_RESET = 13'd64;
   localparam logic [13:0] HIDDEN_SIZE_RESET = 14'd256;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_HIDDEN_SIZE = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_ROW = 2'd1;
   localparam logic [1:0] STATUS_BAD_GROUP = 2'd2;
   localparam logic [1:0] STATUS_BAD_CONFIG = 2'd3;

   localparam logic [15:0] FP16_QNAN = 16'h7E00;
   localparam logic [15:0] FP16_INF = 16'h7C00;

   typedef struct packed {
      logic        op;
      logic [15:0] write_address;
      logic [7:0]  write_byte;
      logic [11:0] row;
      logic [7:0]  group_index;
   } req_type;

   typedef struct packed {
      logic [15:0] value;
      logic [12:0] element_index;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

### design/int4_fractal_embedding_dequant.sv
// Top level of the int4 fractal embedding dequantizer: store, sequencer and fp16 pipeline.
//
// Usage. The block holds a byte store with a table of signed 4-bit weights in
// a fractal layout, followed by one fp16 scale per group of 32 weights.
// A request transfer happens at a rising edge where start is high and busy is
// low. A write request (op 0) stores one byte in that same cycle; it makes no
// result and busy stays low, so writes can stream one per cycle while no read holds busy.
// A read request (op 1) names a row and a group of 32 columns. The sequencer
// does checks and address arithmetic in states CFG, CHK, ADR and SOFF (one
// multiplier per step), fetches the scale bytes in SCLO and SCHI, and then reads
// one weight byte per cycle from the single store port. Results leave through
// a two stage fp16 multiply and round pipeline, so the 32 results arrive back
// to back. A read keeps busy high through the checks, the scale fetch, the
// weight reads and the drain of the pipeline; the store read port sets that.
// An error (bad configuration, row or group) gives a single result with
// last set, registered from the check step; busy is high only in CFG and CHK.
// Each result is shown for one cycle with rsp_valid; the receiver cannot stall.
// Reset clears the control state and loads the register defaults; the store
// contents stay undefined until written.
module int4_fractal_embedding_dequant
   import i4fed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [13:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_CFG, S_CHK, S_ADR, S_SOFF, S_SCLO, S_SCHI, S_LANE, S_DRAIN
   } state_type;

   // Byte store with one write port and one registered read port.
   logic [7:0] mem [BLOB_BYTES];
   logic [7:0] rdata_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic mem_we;

   state_type state_ff;
   logic [12:0] rows_ff;
   logic [13:0] hid_ff;
   logic [11:0] row_ff;
   logic [7:0]  grp_ff;
   logic [21:0] groups_ff;
   logic [24:0] proda_ff;
   logic [6:0]  nc_ff;
   logic [10:0] kc_ff;
   logic [24:0] cell_ff;
   logic [ADDR_W-1:0] soff_ff;
   logic [7:0]  scale_lo_ff;
   logic [15:0] scale_ff;
   logic        hi_ff;
   logic [4:0]  lane_ff;

   // Read stage and fp16 stages.
   logic        rd_v_ff;
   logic [4:0]  rd_lane_ff;
   logic        a_v_ff;
   logic [4:0]  a_lane_ff;
   logic [14:0] p_ff;
   logic [4:0]  e_ff;
   logic        rs_ff;
   logic        spec_ff;
   logic [15:0] specval_ff;

   logic        out_v_ff;
   rsp_type     out_ff;

   // Request side.
   logic        accept;
   logic [11:0] n0;
   logic [12:0] nc_full;
   logic [12:0] kb;
   logic [12:0] k0;
   logic [13:0] kc_full;
   logic        cfg_bad;
   logic        chk_err;

   // Lane addressing.
   logic [9:0]  kr;
   logic [8:0]  fractal;
   logic [6:0]  pidx;
   logic [6:0]  ph4;
   logic [24:0] lane_addr;

   // Stage A.
   logic [3:0]  nib;
   logic [3:0]  wm;
   logic        wneg;
   logic [10:0] mag;
   logic        rs_a;
   logic [15:0] spec_a;

   // Stage B.
   logic [3:0]  msb;
   logic [2:0]  sh;
   logic [14:0] rem;
   logic [14:0] half;
   logic [11:0] mant;
   logic [6:0]  expv;
   logic [4:0]  eadj;
   logic [15:0] value_b;

   assign accept = start && !busy;
   assign mem_we = accept && (req.op == OP_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req.write_address[ADDR_W-1:0]] <= req.write_byte;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign n0 = {row_ff[11:6], 6'd0};
   assign nc_full = rows_ff - {1'b0, n0};
   assign kb = {grp_ff, 5'd0};
   assign k0 = {kb[12:10], 10'd0};
   assign kc_full = hid_ff - {1'b0, k0};
   assign cfg_bad = (rows_ff == 13'd0) || (rows_ff[3:0] != 4'd0) || (hid_ff == 14'd0) ||
                    (hid_ff[4:0] != 5'd0) || (groups_ff > 22'(MAX_GROUPS));
   // A failed check ends a read with a single error result.
   assign chk_err = (state_ff == S_CHK) &&
                    (cfg_bad || ({1'b0, row_ff} >= rows_ff) ||
                     ({1'b0, grp_ff} >= hid_ff[13:5]));

   // Weight byte of one lane: fractal cell, then the phase-4 byte order.
   assign kr = {kb[9:5], lane_ff};
   assign fractal = 9'(kr[9:4] * nc_ff[6:4]) + {7'd0, row_ff[5:4]};
   assign pidx = {row_ff[3:0], lane_ff[3:1]};
   assign ph4 = {pidx[4:0], pidx[6:5]};
   assign lane_addr = cell_ff + {9'd0, fractal, 7'd0} + {18'd0, ph4};

   always_comb begin
      case (state_ff)
         S_SCLO:  rd_addr = soff_ff;
         S_SCHI:  rd_addr = soff_ff + ADDR_W'(1);
         default: rd_addr = lane_addr[ADDR_W-1:0];
      endcase
   end

   // Stage A: pick the nibble and form the exact integer product.
   always_comb begin
      nib = rd_lane_ff[0] ? rdata_ff[7:4] : rdata_ff[3:0];
      wneg = nib[3];
      wm = wneg ? (4'd0 - nib) : nib;
      mag = (scale_ff[14:10] != 5'd0) ? {1'b1, scale_ff[9:0]} : {1'b0, scale_ff[9:0]};
      rs_a = scale_ff[15] ^ wneg;
      if (scale_ff[9:0] != 10'd0) begin
         spec_a = {scale_ff[15], 15'd0} | FP16_QNAN;
      end else if (wm == 4'd0) begin
         spec_a = FP16_QNAN;
      end else begin
         spec_a = {rs_a, 15'd0} | FP16_INF;
      end
   end

   // Stage B: normalize and round to nearest even.
   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (p_ff[i]) begin
            msb = 4'(i);
         end
      end
      eadj = (e_ff == 5'd0) ? 5'd1 : e_ff;
      sh = 3'd0;
      rem = 15'd0;
      half = 15'd0;
      if (msb <= 4'd10) begin
         mant = 12'(p_ff << (4'd10 - msb));
      end else begin
         sh = 3'(msb - 4'd10);
         mant = 12'(p_ff >> sh);
         rem = p_ff & ((15'd1 << sh) - 15'd1);
         half = 15'd1 << (sh - 3'd1);
         if ((rem > half) || ((rem == half) && mant[0])) begin
            mant = mant + 12'd1;
         end
      end
      expv = 7'(msb) + 7'(eadj) - 7'd10;
      if (mant[11]) begin
         mant = mant >> 1;
         expv = expv + 7'd1;
      end
      if (spec_ff) begin
         value_b = specval_ff;
      end else if (p_ff == 15'd0) begin
         value_b = {rs_ff, 15'd0};
      end else if ((e_ff == 5'd0) && (p_ff < 15'd1024)) begin
         value_b = {rs_ff, 5'd0, p_ff[9:0]};
      end else if (expv > 7'd30) begin
         value_b = {rs_ff, 15'd0} | FP16_INF;
      end else begin
         value_b = {rs_ff, expv[4:0], mant[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= ROW_COUNT_RESET;
         hid_ff <= HIDDEN_SIZE_RESET;
         rd_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         hi_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROW_COUNT:   rows_ff <= csr_wdata[12:0];
               CSR_HIDDEN_SIZE: hid_ff <= csr_wdata;
            endcase
         end

         out_v_ff <= a_v_ff || chk_err;
         a_v_ff <= rd_v_ff;
         rd_v_ff <= (state_ff == S_LANE);
         hi_ff <= (state_ff == S_SCHI);

         a_lane_ff <= rd_lane_ff;
         p_ff <= 15'(wm * mag);
         e_ff <= scale_ff[14:10];
         rs_ff <= rs_a;
         spec_ff <= (scale_ff[14:10] == 5'h1F);
         specval_ff <= spec_a;

         if (a_v_ff) begin
            out_ff.value <= value_b;
            out_ff.element_index <= {grp_ff, a_lane_ff};
            out_ff.status <= STATUS_OK;
            out_ff.last <= (a_lane_ff == 5'd31);
         end

         if (hi_ff) begin
            scale_ff <= {rdata_ff, scale_lo_ff};
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req.op == OP_READ)) begin
                  row_ff <= req.row;
                  grp_ff <= req.group_index;
                  state_ff <= S_CFG;
               end
            end
            S_CFG: begin
               groups_ff <= rows_ff * hid_ff[13:5];
               state_ff <= S_CHK;
            end
            S_CHK: begin
               proda_ff <= n0 * hid_ff[13:1];
               nc_ff <= (nc_full < 13'd64) ? nc_full[6:0] : 7'd64;
               kc_ff <= (kc_full < 14'd1024) ? kc_full[10:0] : 11'd1024;
               out_ff.value <= 16'd0;
               out_ff.element_index <= 13'd0;
               out_ff.last <= 1'b1;
               if (cfg_bad) begin
                  out_ff.status <= STATUS_BAD_CONFIG;
                  state_ff <= S_IDLE;
               end else if ({1'b0, row_ff} >= rows_ff) begin
                  out_ff.status <= STATUS_BAD_ROW;
                  state_ff <= S_IDLE;
               end else if ({1'b0, grp_ff} >= hid_ff[13:5]) begin
                  out_ff.status <= STATUS_BAD_GROUP;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_ADR;
               end
            end
            S_ADR: begin
               cell_ff <= proda_ff + 25'(nc_ff * k0[12:1]);
               state_ff <= S_SOFF;
            end
            S_SOFF: begin
               // Scale offsets are the weight offsets divided by eight, past the weights.
               soff_ff <= ADDR_W'({groups_ff, 4'd0} + {4'd0, cell_ff[24:3]} +
                                  26'(row_ff[5:0] * kc_ff[10:4]) + {20'd0, kb[9:4]});
               state_ff <= S_SCLO;
            end
            S_SCLO: begin
               state_ff <= S_SCHI;
            end
            S_SCHI: begin
               scale_lo_ff <= rdata_ff;
               lane_ff <= 5'd0;
               state_ff <= S_LANE;
            end
            S_LANE: begin
               rd_lane_ff <= lane_ff;
               lane_ff <= lane_ff + 5'd1;
               if (lane_ff == 5'd31) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!rd_v_ff && !a_v_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp = out_ff;

   // An error result always closes its read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_OK) |-> rsp.last)
      else $error("error result without last");

   // A last result is never followed by another result of the same read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |=> !rsp_valid)
      else $error("result after last");

   // A read transfer raises busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req.op == OP_READ) |=> busy)
      else $error("read transfer did not raise busy");

   // Lane reads only happen while the sequencer walks the lanes.
   assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> (state_ff == S_LANE) || (state_ff == S_DRAIN))
      else $error("lane read outside lane walk");

endmodule

### verif/tb.sv
// Self-checking testbench for the int4 fractal embedding dequantizer.
module tb
   import i4fed_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   // Quiet time after the last result before a register write or the end.
   localparam int SETTLE_CYCLES = 60;
   localparam int REQ_W = $bits(req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req = '0;
   logic        rsp_valid;
   rsp_type     rsp;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_ROW_COUNT;
   logic [13:0] csr_wdata = '0;

   int_fractal_dummy_guard guard_unused ();

   int4_fractal_embedding_dequant uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Mirror of the block state as the predictor sees it.
   logic [7:0]  shadow_store [BLOB_BYTES];
   int unsigned shadow_rows = ROW_COUNT_RESET;
   int unsigned shadow_hidden = HIDDEN_SIZE_RESET;
   // Bytes that the stimulus has already queued a write for.
   bit          store_written [BLOB_BYTES];

   req_type pending_items [$];
   rsp_type expected_elements [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;

   // Exact product of a signed 4-bit weight and an fp16 scale, rounded to
   // fp16 with round-to-nearest-even.
   function automatic logic [15:0] fp16_scaled(int w, logic [15:0] h);
      int unsigned e, f, wm, mag, p, m, rem, half;
      int          ex, b, lead, sh;
      logic [15:0] rs;
      e = h[14:10];
      f = h[9:0];
      wm = (w < 0) ? -w : w;
      rs = {(h[15] ^ (w < 0)), 15'd0};
      if (e == 31) begin
         if (f != 0) return {h[15], 15'd0} | FP16_QNAN;
         if (wm == 0) return FP16_QNAN;
         return rs | FP16_INF;
      end
      mag = (e != 0) ? (f | 32'h400) : f;
      ex = (e != 0) ? int'(e) - 25 : -24;
      p = wm * mag;
      if (p == 0) return rs;
      b = 0;
      while ((p >> (b + 1)) != 0) b++;
      lead = b + ex;
      // Below the normal range the product is an exact subnormal.
      if (lead < -14) begin
         m = p << (ex + 24);
         return rs | 16'(m & 32'h3FF);
      end
      sh = b - 10;
      if (sh <= 0) begin
         m = p << (-sh);
      end else begin
         rem = p & ((32'd1 << sh) - 1);
         half = 32'd1 << (sh - 1);
         m = p >> sh;
         if (rem > half || (rem == half && m[0])) m++;
      end
      if (m >= 2048) begin
         m >>= 1;
         lead++;
      end
      if (lead > 15) return rs | FP16_INF;
      return rs | 16'((lead + 15) << 10) | 16'(m & 32'h3FF);
   endfunction

   function automatic bit layout_fits(int unsigned rows, int unsigned hid);
      longint unsigned groups;
      if (rows == 0 || hid == 0 || rows % 16 != 0 || hid % 32 != 0) return 1'b0;
      groups = longint'(rows) * (hid / 32);
      return groups * 18 <= BLOB_BYTES;
   endfunction

   // Byte address of the scale that covers one row and group.
   function automatic longint unsigned scale_address(int unsigned rows, int unsigned hid,
                                                     int unsigned n, int unsigned g);
      longint unsigned n0, nc, kb, k0, kc;
      n0 = n / 64 * 64;
      nc = (rows - n0 < 64) ? rows - n0 : 64;
      kb = g * 32;
      k0 = kb / 1024 * 1024;
      kc = (hid - k0 < 1024) ? hid - k0 : 1024;
      return longint'(rows) * (hid / 32) * 16 + n0 * (hid / 16) + nc * (k0 / 16)
             + (n - n0) * (kc / 16) + (kb - k0) / 16;
   endfunction

   // Byte address of the weight of one lane of a row and group.
   function automatic longint unsigned weight_address(int unsigned rows, int unsigned hid,
                                                      int unsigned n, int unsigned g,
                                                      int unsigned lane);
      longint unsigned n0, nc, kb, k0, k, cell_base, fractal, flat, pidx, ph4;
      n0 = n / 64 * 64;
      nc = (rows - n0 < 64) ? rows - n0 : 64;
      kb = g * 32;
      k0 = kb / 1024 * 1024;
      cell_base = n0 * (hid / 2) + nc * (k0 / 2);
      k = kb + lane;
      fractal = ((k - k0) / 16) * (nc / 16) + (n - n0) / 16;
      flat = (n % 16) * 16 + k % 16;
      pidx = flat / 2;
      // Phase-4 order interleaves the 128 bytes of a fractal in four passes.
      ph4 = 4 * (pidx % 32) + pidx / 32;
      return cell_base + fractal * 128 + ph4;
   endfunction

   function automatic logic [7:0] shadow_read(longint unsigned a);
      return (a < BLOB_BYTES) ? shadow_store[a] : 8'd0;
   endfunction

   function automatic rsp_type error_element(logic [1:0] code);
      rsp_type r;
      r = '0;
      r.status = code;
      r.last = 1'b1;
      return r;
   endfunction

   // Works out the results of one accepted transfer and queues them.
   task automatic predict_transfer(req_type item);
      longint unsigned k, sa, wa;
      logic [15:0]     scale;
      logic [7:0]      packed_byte;
      logic [3:0]      nib;
      rsp_type         r;
      if (item.op == OP_WRITE) begin
         shadow_store[item.write_address] = item.write_byte;
         return;
      end
      if (!layout_fits(shadow_rows, shadow_hidden)) begin
         expected_elements.push_back(error_element(STATUS_BAD_CONFIG));
         return;
      end
      if (item.row >= shadow_rows) begin
         expected_elements.push_back(error_element(STATUS_BAD_ROW));
         return;
      end
      if (item.group_index >= shadow_hidden / 32) begin
         expected_elements.push_back(error_element(STATUS_BAD_GROUP));
         return;
      end
      sa = scale_address(shadow_rows, shadow_hidden, item.row, item.group_index);
      scale = {shadow_read(sa + 1), shadow_read(sa)};
      for (int lane = 0; lane < 32; lane++) begin
         k = item.group_index * 32 + lane;
         wa = weight_address(shadow_rows, shadow_hidden, item.row, item.group_index, lane);
         packed_byte = shadow_read(wa);
         // Odd columns sit in the high nibble.
         nib = (lane % 2 != 0) ? packed_byte[7:4] : packed_byte[3:0];
         r.value = fp16_scaled(int'($signed(nib)), scale);
         r.element_index = 13'(k);
         r.status = STATUS_OK;
         r.last = (lane == 31);
         expected_elements.push_back(r);
      end
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch in %s at cycle %0d: got 0x%0h, expected 0x%0h",
               field, cycle_count, got, want);
      mismatch_count++;
   endtask

   // Sender: bursts of transfers separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      bit taken;
      bit holding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            predict_transfer(req);
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               // A long burst now and then leaves stretches with no idling.
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 8);
               gap_left = $urandom_range(0, 5);
            end
         end
         holding = start && !taken;
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req <= pending_items.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Receiver: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_elements.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp), 0);
         end else begin
            want = expected_elements.pop_front();
            if (rsp.value !== want.value) report_mismatch("value", rsp.value, want.value);
            if (rsp.element_index !== want.element_index)
               report_mismatch("element_index", rsp.element_index, want.element_index);
            if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
            if (rsp.last !== want.last) report_mismatch("last", rsp.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[int4_fractal_embedding_dequant] ERROR");
         $finish;
      end
   end

   function automatic req_type write_item(logic [15:0] a, logic [7:0] d);
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      r.op = OP_WRITE;
      r.write_address = a;
      r.write_byte = d;
      return r;
   endfunction

   function automatic req_type read_item(logic [11:0] n, logic [7:0] g);
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      r.op = OP_READ;
      r.row = n;
      r.group_index = g;
      return r;
   endfunction

   function automatic logic [15:0] special_scale();
      case ($urandom_range(0, 12))
         0: return FP16_QNAN;
         1: return 16'hFE01;
         2: return FP16_INF;
         3: return 16'hFC00;
         4: return 16'h0000;
         5: return 16'h8000;
         6: return 16'h0001;
         7: return 16'h83FF;
         8: return 16'h0400;
         9: return 16'h7BFF;
         10: return 16'h5BFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Queues a random write for every byte of a row and group not yet written,
   // so a read never touches a byte the store has not been given.
   task automatic cover_group(int unsigned n, int unsigned g);
      longint unsigned a;
      for (int lane = 0; lane < 32; lane++) begin
         a = weight_address(shadow_rows, shadow_hidden, n, g, lane);
         if (!store_written[a]) begin
            store_written[a] = 1'b1;
            pending_items.push_back(write_item(16'(a), 8'($urandom)));
         end
      end
      a = scale_address(shadow_rows, shadow_hidden, n, g);
      for (int i = 0; i < 2; i++) begin
         if (!store_written[a + i]) begin
            store_written[a + i] = 1'b1;
            pending_items.push_back(write_item(16'(a + i), 8'($urandom)));
         end
      end
   endtask

   // Places a chosen scale on a valid row and group, then reads that group.
   task automatic queue_scaled_read(logic [15:0] scale, int unsigned n, int unsigned g);
      longint unsigned sa;
      sa = scale_address(shadow_rows, shadow_hidden, n, g);
      store_written[sa] = 1'b1;
      store_written[sa + 1] = 1'b1;
      pending_items.push_back(write_item(16'(sa), scale[7:0]));
      pending_items.push_back(write_item(16'(sa + 1), scale[15:8]));
      cover_group(n, g);
      pending_items.push_back(read_item(12'(n), 8'(g)));
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || start || expected_elements.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [13:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_ROW_COUNT) shadow_rows = data[12:0];
      else shadow_hidden = data;
   endtask

   logic [13:0] phase_rows [10] = '{14'd64, 14'd16, 14'd112, 14'd48, 14'd16,
                                    14'h3FFF, 14'd0, 14'd20, 14'd4096, 14'd112};
   logic [13:0] phase_hidden [10] = '{14'd256, 14'd32, 14'd1024, 14'd2048, 14'd1056,
                                      14'h3FFF, 14'd0, 14'd32, 14'd48, 14'd1024};

   initial begin
      int unsigned kind, n, g, last_g, sel, wa;
      int unsigned pool_n [3];
      int unsigned pool_g [3];
      bool_dummy_guard_init();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase > 0) begin
            wait_idle();
            write_register(CSR_ROW_COUNT, phase_rows[phase]);
            write_register(CSR_HIDDEN_SIZE, phase_hidden[phase]);
            @(posedge clock);
            csr_we <= 1'b0;
         end
         if (layout_fits(shadow_rows, shadow_hidden)) begin
            last_g = shadow_hidden / 32 - 1;
            // A small pool of rows and groups keeps the store fill short.
            for (int i = 0; i < 3; i++) begin
               pool_n[i] = $urandom_range(0, shadow_rows - 1);
               pool_g[i] = $urandom_range(0, last_g);
            end
            if (phase == 0 || phase == 2) begin
               // Corner rows and groups, special scales, and the error cases.
               pool_n[0] = 0;
               pool_g[0] = 0;
               pool_n[1] = shadow_rows - 1;
               pool_g[1] = last_g;
               pool_n[2] = shadow_rows - 1;
               pool_g[2] = 0;
               for (int i = 0; i < 3; i++)
                  queue_scaled_read(special_scale(), pool_n[i], pool_g[i]);
               pending_items.push_back(read_item(12'hFFF, 8'd0));
               pending_items.push_back(read_item(12'd0, 8'hFF));
               pending_items.push_back(read_item(12'(shadow_rows), 8'(last_g + 1)));
            end
            for (int i = 0; i < 12; i++) begin
               kind = $urandom_range(0, 9);
               sel = $urandom_range(0, 2);
               n = pool_n[sel];
               g = pool_g[sel];
               if (kind < 2) begin
                  wa = $urandom_range(0, BLOB_BYTES - 1);
                  store_written[wa] = 1'b1;
                  pending_items.push_back(write_item(16'(wa), 8'($urandom)));
               end else if (kind < 4) begin
                  queue_scaled_read(special_scale(), n, g);
               end else if (kind == 4) begin
                  // A row or a group out of range.
                  if ($urandom_range(0, 1) == 0)
                     pending_items.push_back(
                        read_item(12'($urandom_range(shadow_rows, 4095)), 8'(g)));
                  else
                     pending_items.push_back(
                        read_item(12'(n), 8'($urandom_range(last_g + 1, 255))));
               end else begin
                  cover_group(n, g);
                  pending_items.push_back(read_item(12'(n), 8'(g)));
               end
            end
         end else begin
            for (int i = 0; i < 8; i++)
               pending_items.push_back(read_item(12'($urandom), 8'($urandom)));
         end
      end
      wait_idle();
      if (mismatch_count == 0) begin
         $display("[int4_fractal_embedding_dequant] OK");
      end else begin
         $display("[int4_fractal_embedding_dequant] ERROR");
      end
      $finish;
   end

   task automatic bool_dummy_guard_init();
   endtask

   // Outstanding expectations at the end hold wait_idle until the cycle limit ends the run with ERROR.
   final_check_unused unused_final ();

endmodule

module int_fractal_dummy_guard;
   timeunit 1ns;
   timeprecision 1ps;
endmodule

module final_check_unused;
   timeunit 1ns;
   timeprecision 1ps;
endmodule

### int4_fractal_embedding_dequant.f
design/i4fed_pkg.sv
design/int4_fractal_embedding_dequant.sv
verif/tb.sv
